FILE: design/mic_pkg.sv
`timescale 1ns / 1ps

package mic_pkg;

    localparam int MAX_MATERIALS_DEF = 64;
    localparam int COUNT_BITS_DEF    = 17;

    // fixed field widths
    localparam int CMD_W = 3;
    localparam int IDX_W = 7;
    localparam int POS_W = 6;
    localparam int NUM_W = 7;
    localparam int ORG_W = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR    = 3'd0,
        CMD_COUNT    = 3'd1,
        CMD_FINALIZE = 3'd2,
        CMD_REMAP    = 3'd3,
        CMD_READ     = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_FIN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic walk;
        logic fin;
    } t_dp_ctl;

    // datapath -> controller
    typedef struct packed {
        logic walk_last;
    } t_dp_sts;

endpackage

FILE: design/mic_ctrl.sv
`timescale 1ns / 1ps

module mic_ctrl
    import mic_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [CMD_W-1:0] i_cmd,
    input  t_dp_sts          i_sts,
    output t_dp_ctl          o_ctl,
    output logic             busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        busy    = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_ctl.load = 1'b1;
                    if (i_cmd == CMD_FINALIZE) begin
                        n_state = ST_WALK;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                o_ctl.exec = 1'b1;
                n_state    = ST_IDLE;
            end
            ST_WALK: begin
                o_ctl.walk = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_ctl.fin = 1'b1;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/mic_datapath.sv
`timescale 1ns / 1ps

module mic_datapath
    import mic_pkg::*;
#(
    parameter int MAX_MATERIALS = MAX_MATERIALS_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_ctl                 i_ctl,
    output t_dp_sts                 o_sts,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic signed [IDX_W-1:0] i_material_index,
    input  logic [POS_W-1:0]        i_map_position,
    output logic                    o_valid,
    output logic signed [IDX_W-1:0] o_new_index,
    output logic [NUM_W-1:0]        o_used_count,
    output logic                    o_remap_applied,
    output logic [ORG_W-1:0]        o_import_index,
    output logic                    o_error
);

    localparam int AW = (MAX_MATERIALS > 1) ? $clog2(MAX_MATERIALS) : 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_MATERIALS - 1);

    // storage
    logic [COUNT_BITS-1:0]   m_counts [MAX_MATERIALS];
    logic signed [NUM_W-1:0] m_o2d    [MAX_MATERIALS];
    logic [ORG_W-1:0]        m_d2o    [MAX_MATERIALS];

    // latched request and read data
    logic [CMD_W-1:0]        r_cmd;
    logic signed [IDX_W-1:0] r_idx;
    logic [POS_W-1:0]        r_pos;
    logic [COUNT_BITS-1:0]   r_cnt_rd;
    logic signed [NUM_W-1:0] r_o2d_rd;
    logic [ORG_W-1:0]        r_d2o_rd;

    // control state
    logic [MAX_MATERIALS-1:0] r_cnt_vld, n_cnt_vld;
    logic [NUM_W-1:0]         r_slots, n_slots;
    logic [NUM_W-1:0]         r_dense_total, n_dense_total;
    logic                     r_comp, n_comp;
    logic [AW-1:0]            r_walk, n_walk;
    logic [NUM_W-1:0]         r_n, n_n;
    logic                     r_valid, n_valid;

    // result registers
    logic signed [IDX_W-1:0]  r_new_index, n_new_index;
    logic [NUM_W-1:0]         r_used, n_used;
    logic                     r_applied, n_applied;
    logic [ORG_W-1:0]         r_import, n_import;
    logic                     r_err, n_err;

    logic [AW-1:0]            w_in_idx_addr;
    logic [AW-1:0]            w_in_pos_addr;
    logic [AW-1:0]            w_idx_addr;
    logic                     w_idx_neg;
    logic                     w_idx_oor;
    logic [COUNT_BITS-1:0]    w_cnt_cur;
    logic [NUM_W-1:0]         w_idx_plus1;
    logic                     w_slot_used;
    logic                     w_cnt_we;
    logic [COUNT_BITS-1:0]    w_cnt_wdata;

    assign w_in_idx_addr = AW'(i_material_index[IDX_W-2:0]);
    assign w_in_pos_addr = AW'(i_map_position);
    assign w_idx_addr    = AW'(r_idx[IDX_W-2:0]);
    assign w_idx_neg     = r_idx[IDX_W-1];
    assign w_idx_oor     = !w_idx_neg &&
                           (32'(r_idx[IDX_W-2:0]) >= 32'(MAX_MATERIALS));
    assign w_cnt_cur     = r_cnt_vld[w_idx_addr] ? r_cnt_rd : '0;
    assign w_idx_plus1   = {1'b0, r_idx[IDX_W-2:0]} + NUM_W'(1);
    assign w_slot_used   = r_cnt_vld[r_walk] && (32'(r_walk) < 32'(r_slots));
    assign w_cnt_we      = i_ctl.exec && (r_cmd == CMD_COUNT) && !w_idx_neg && !w_idx_oor;
    assign w_cnt_wdata   = (w_cnt_cur == COUNT_MAX) ? w_cnt_cur : w_cnt_cur + 1'b1;

    assign o_sts.walk_last = (r_walk == LAST_SLOT);

    always_comb begin
        n_cnt_vld     = r_cnt_vld;
        n_slots       = r_slots;
        n_dense_total = r_dense_total;
        n_comp        = r_comp;
        n_walk        = r_walk;
        n_n           = r_n;
        n_valid       = 1'b0;
        n_new_index   = -IDX_W'(1);
        n_used        = '0;
        n_applied     = r_comp;
        n_import      = '0;
        n_err         = 1'b0;

        if (i_ctl.load) begin
            n_walk = '0;
            n_n    = '0;
        end

        if (i_ctl.exec) begin
            n_valid = 1'b1;
            unique case (r_cmd)
                CMD_CLEAR: begin
                    n_cnt_vld = '0;
                    n_slots   = '0;
                end
                CMD_COUNT: begin
                    if (w_idx_oor) begin
                        n_err = 1'b1;
                    end else if (!w_idx_neg) begin
                        n_cnt_vld[w_idx_addr] = 1'b1;
                        if (w_idx_plus1 > r_slots) begin
                            n_slots = w_idx_plus1;
                        end
                    end
                end
                CMD_REMAP: begin
                    if (w_idx_oor) begin
                        n_err = 1'b1;
                    end else if (!w_idx_neg) begin
                        n_new_index = r_comp ? r_o2d_rd : r_idx;
                    end
                end
                CMD_READ: begin
                    if ((NUM_W'(r_pos) < r_dense_total) &&
                        (32'(r_pos) < 32'(MAX_MATERIALS))) begin
                        n_import = r_d2o_rd;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_ctl.walk) begin
            n_walk = r_walk + 1'b1;
            if (w_slot_used) begin
                n_n = r_n + 1'b1;
            end
        end

        if (i_ctl.fin) begin
            n_valid = 1'b1;
            n_used  = r_n;
            if (r_n == r_slots) begin
                n_dense_total = '0;
                n_comp        = 1'b0;
            end else begin
                n_dense_total = r_n;
                n_comp        = 1'b1;
            end
            n_applied = n_comp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld     <= '0;
            r_slots       <= '0;
            r_dense_total <= '0;
            r_comp        <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            r_cnt_vld     <= n_cnt_vld;
            r_slots       <= n_slots;
            r_dense_total <= n_dense_total;
            r_comp        <= n_comp;
            r_valid       <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk      <= n_walk;
        r_n         <= n_n;
        r_new_index <= n_new_index;
        r_used      <= n_used;
        r_applied   <= n_applied;
        r_import    <= n_import;
        r_err       <= n_err;
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
            r_idx <= i_material_index;
            r_pos <= i_map_position;
        end
    end

    // memory reads issued in the accept cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cnt_rd <= m_counts[w_in_idx_addr];
            r_o2d_rd <= m_o2d[w_in_idx_addr];
            r_d2o_rd <= m_d2o[w_in_pos_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            m_counts[w_idx_addr] <= w_cnt_wdata;
        end
    end

    // finalize: one slot per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.walk) begin
            m_o2d[r_walk] <= w_slot_used ? signed'(r_n) : -NUM_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.walk && w_slot_used) begin
            m_d2o[AW'(r_n)] <= ORG_W'(r_walk);
        end
    end

    assign o_valid         = r_valid;
    assign o_new_index     = r_new_index;
    assign o_used_count    = r_used;
    assign o_remap_applied = r_applied;
    assign o_import_index  = r_import;
    assign o_error         = r_err;

endmodule

FILE: design/material_index_compactor.sv
`timescale 1ns / 1ps
// Channel   Handshake            Ports
// request   start & !busy        i_cmd, i_material_index, i_map_position
// result    o_valid (1 cycle)    o_new_index, o_used_count, o_remap_applied,
//                                o_import_index, o_error
//
// Clear, count, remap, read: accept issues the registered memory read, ST_EXEC
// uses it and registers the strobe; no new request is taken while in ST_EXEC.
// Finalize walks the histogram one slot per cycle in ST_WALK, then strobes from ST_FIN.
// Reset (synchronous, i_rst_n low) empties the histogram at once via valid bits.
// Results are not held: the receiver takes each one in its strobe cycle.

module material_index_compactor
    import mic_pkg::*;
#(
    parameter int MAX_MATERIALS = MAX_MATERIALS_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic signed [IDX_W-1:0] i_material_index,
    input  logic [POS_W-1:0]        i_map_position,
    output logic                    o_valid,
    output logic signed [IDX_W-1:0] o_new_index,
    output logic [NUM_W-1:0]        o_used_count,
    output logic                    o_remap_applied,
    output logic [ORG_W-1:0]        o_import_index,
    output logic                    o_error
);

    t_dp_ctl w_ctl;
    t_dp_sts w_sts;

    mic_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl),
        .busy    (busy)
    );

    mic_datapath #(
        .MAX_MATERIALS (MAX_MATERIALS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (w_ctl),
        .o_sts            (w_sts),
        .i_cmd            (i_cmd),
        .i_material_index (i_material_index),
        .i_map_position   (i_map_position),
        .o_valid          (o_valid),
        .o_new_index      (o_new_index),
        .o_used_count     (o_used_count),
        .o_remap_applied  (o_remap_applied),
        .o_import_index   (o_import_index),
        .o_error          (o_error)
    );

endmodule

FILE: test/mic_checker.sv
`timescale 1ns / 1ps

module mic_checker
    import mic_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic signed [IDX_W-1:0] i_material_index,
    input  logic [POS_W-1:0]        i_map_position,
    input  logic                    o_valid,
    input  logic signed [IDX_W-1:0] o_new_index,
    input  logic [NUM_W-1:0]        o_used_count,
    input  logic                    o_remap_applied,
    input  logic [ORG_W-1:0]        o_import_index,
    input  logic                    o_error,
    output int                      mismatches,
    output int                      outstanding
);

    localparam int SLOTS = MAX_MATERIALS_DEF;
    localparam logic [COUNT_BITS_DEF-1:0] COUNT_FULL = '1;

    typedef struct packed {
        logic signed [IDX_W-1:0] new_index;
        logic [NUM_W-1:0]        used_count;
        logic                    remap_applied;
        logic [ORG_W-1:0]        import_index;
        logic                    error;
    } t_answer;

    // shadow copy of the compactor state
    logic [COUNT_BITS_DEF-1:0] face_tally [SLOTS];
    int                        slot_span;
    int                        dense_of [SLOTS];
    logic [ORG_W-1:0]          origin_of [SLOTS];
    int                        dense_len;
    logic                      compacting;

    t_answer                   awaited_answers [$];

    function automatic void clear_tally();
        for (int s = 0; s < SLOTS; s++) face_tally[s] = '0;
        slot_span = 0;
    endfunction

    function automatic void reset_shadow();
        clear_tally();
        for (int s = 0; s < SLOTS; s++) begin
            dense_of[s]  = 0;
            origin_of[s] = '0;
        end
        dense_len  = 0;
        compacting = 1'b0;
    endfunction

    function automatic t_answer compact_step(input logic [CMD_W-1:0] cmd,
                                             input logic signed [IDX_W-1:0] mat,
                                             input logic [POS_W-1:0] pos);
        t_answer a;
        int      idx;
        int      n;
        a.new_index    = -1;
        a.used_count   = '0;
        a.import_index = '0;
        a.error        = 1'b0;
        idx = mat;
        n   = 0;
        case (cmd)
            CMD_CLEAR: begin
                clear_tally();
            end
            CMD_COUNT: begin
                if (idx >= SLOTS) begin
                    a.error = 1'b1;
                end else if (idx >= 0) begin
                    if (idx + 1 > slot_span) slot_span = idx + 1;
                    if (face_tally[idx] != COUNT_FULL) face_tally[idx]++;
                end
            end
            CMD_FINALIZE: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (s < slot_span && face_tally[s] != '0) begin
                        dense_of[s]  = n;
                        origin_of[n] = s;
                        n++;
                    end else begin
                        dense_of[s] = -1;
                    end
                end
                a.used_count = n;
                // no gaps below the highest index: maps are dropped
                if (n == slot_span) begin
                    dense_len  = 0;
                    compacting = 1'b0;
                end else begin
                    dense_len  = n;
                    compacting = 1'b1;
                end
            end
            CMD_REMAP: begin
                if (idx >= SLOTS) a.error = 1'b1;
                else if (idx >= 0) a.new_index = compacting ? dense_of[idx] : idx;
            end
            CMD_READ: begin
                if (pos < dense_len) a.import_index = origin_of[pos];
                else a.error = 1'b1;
            end
            default: ;
        endcase
        a.remap_applied = compacting;
        return a;
    endfunction

    task automatic check_field(input string field, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            reset_shadow();
            awaited_answers.delete();
            mismatches = 0;
        end else begin
            // retire first: a result never belongs to a request taken at the same edge
            if (o_valid !== 1'b0) begin
                if (awaited_answers.size() == 0) begin
                    $error("result strobe with no request outstanding");
                    mismatches++;
                end else begin
                    want = awaited_answers.pop_front();
                    check_field("new_index", $signed(want.new_index), $signed(o_new_index));
                    check_field("used_count", want.used_count, o_used_count);
                    check_field("remap_applied", want.remap_applied, o_remap_applied);
                    check_field("import_index", want.import_index, o_import_index);
                    check_field("error", want.error, o_error);
                end
            end
            if (start && !busy)
                awaited_answers.push_back(compact_step(i_cmd, i_material_index,
                                                       i_map_position));
        end
        outstanding = awaited_answers.size();
    end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mic_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    localparam int               RANDOM_ITEMS = 1000;

    logic                    i_clk            = 1'b0;
    logic                    i_rst_n          = 1'b0;
    logic                    start            = 1'b0;
    logic [CMD_W-1:0]        i_cmd            = '0;
    logic signed [IDX_W-1:0] i_material_index = '0;
    logic [POS_W-1:0]        i_map_position   = '0;
    logic                    busy;
    logic                    o_valid;
    logic signed [IDX_W-1:0] o_new_index;
    logic [NUM_W-1:0]        o_used_count;
    logic                    o_remap_applied;
    logic [ORG_W-1:0]        o_import_index;
    logic                    o_error;

    int mismatches;
    int outstanding;
    int sent    = 0;
    bit idling  = 1'b1;

    always #5 i_clk = ~i_clk;

    material_index_compactor dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_material_index (i_material_index),
        .i_map_position   (i_map_position),
        .o_valid          (o_valid),
        .o_new_index      (o_new_index),
        .o_used_count     (o_used_count),
        .o_remap_applied  (o_remap_applied),
        .o_import_index   (o_import_index),
        .o_error          (o_error)
    );

    mic_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_material_index (i_material_index),
        .i_map_position   (i_map_position),
        .o_valid          (o_valid),
        .o_new_index      (o_new_index),
        .o_used_count     (o_used_count),
        .o_remap_applied  (o_remap_applied),
        .o_import_index   (o_import_index),
        .o_error          (o_error),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    // called and returns at a falling edge; start stays high for the next request
    task automatic send_request(input logic [CMD_W-1:0] cmd, input int mat, input int pos);
        if (idling && $urandom_range(0, 99) < 18) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        start            <= 1'b1;
        i_cmd            <= cmd;
        i_material_index <= mat[IDX_W-1:0];
        i_map_position   <= pos[POS_W-1:0];
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    // one mesh: optional clear, counts, finalize, then lookups
    task automatic run_mesh();
        logic [63:0] in_use;
        int          span;
        int          pick;
        if ($urandom_range(0, 4) != 0) begin
            send_request(CMD_CLEAR, $urandom_range(0, 127), $urandom_range(0, 63));
            sent++;
        end
        case ($urandom_range(0, 9))
            0:       span = MAX_MATERIALS_DEF;
            1:       span = 1;
            default: span = $urandom_range(2, 24);
        endcase
        if ($urandom_range(0, 2) == 0) in_use = '1;
        else in_use = {$urandom, $urandom};
        if (span < 64) in_use &= (64'd1 << span) - 1;
        in_use[span-1] = 1'b1;

        for (int m = 0; m < span; m++) begin
            if (in_use[m]) begin
                send_request(CMD_COUNT, m, $urandom_range(0, 63));
                sent++;
            end
        end
        repeat ($urandom_range(0, 12)) begin
            case ($urandom_range(0, 9))
                0: send_request(CMD_COUNT, -$urandom_range(1, 64), $urandom_range(0, 63));
                1: send_request($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI),
                                $urandom_range(0, 127), $urandom_range(0, 63));
                2: begin
                    // stray face that may lie outside the planned set
                    send_request(CMD_COUNT, $urandom_range(0, 63), $urandom_range(0, 63));
                    sent++;
                end
                default: begin
                    do pick = $urandom_range(0, span - 1); while (!in_use[pick]);
                    send_request(CMD_COUNT, pick, $urandom_range(0, 63));
                    sent++;
                end
            endcase
        end
        send_request(CMD_FINALIZE, $urandom_range(0, 127), $urandom_range(0, 63));
        sent++;
        if ($urandom_range(0, 4) == 0) wait_drained();

        repeat ($urandom_range(2, 12)) begin
            case ($urandom_range(0, 4))
                0: send_request(CMD_REMAP, $urandom_range(0, 127), $urandom_range(0, 63));
                1, 2: send_request(CMD_REMAP, $urandom_range(0, span), $urandom_range(0, 63));
                3: send_request(CMD_READ, $urandom_range(0, 127), $urandom_range(0, span));
                default: send_request(CMD_READ, $urandom_range(0, 127), $urandom_range(0, 63));
            endcase
            sent++;
        end
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty state, extremes of the index, gaps, map reads
        send_request(CMD_REMAP, 17, 0);
        send_request(CMD_READ, 0, 0);
        send_request(CMD_FINALIZE, 0, 0);
        send_request(CMD_COUNT, -64, 63);
        send_request(CMD_COUNT, -1, 0);
        send_request(CMD_COUNT, 63, 0);
        send_request(CMD_COUNT, 0, 0);
        send_request(CMD_FINALIZE, 0, 0);
        send_request(CMD_REMAP, 63, 0);
        send_request(CMD_REMAP, 0, 0);
        send_request(CMD_REMAP, 30, 0);
        send_request(CMD_REMAP, -1, 0);
        send_request(CMD_REMAP, -64, 0);
        send_request(CMD_READ, 0, 0);
        send_request(CMD_READ, 0, 1);
        send_request(CMD_READ, 0, 2);
        send_request(CMD_READ, 0, 63);
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) send_request(c, 5, 5);
        send_request(CMD_CLEAR, 0, 0);
        // maps survive a clear
        send_request(CMD_REMAP, 63, 0);
        send_request(CMD_COUNT, 0, 0);
        send_request(CMD_COUNT, 1, 0);
        send_request(CMD_FINALIZE, 0, 0);
        send_request(CMD_REMAP, 63, 0);
        send_request(CMD_READ, 0, 0);
        wait_drained();

        while (sent < RANDOM_ITEMS) begin
            idling = !(sent >= 400 && sent < 600);
            run_mesh();
        end
        idling = 1'b1;

        wait_drained();
        repeat (MAX_MATERIALS_DEF + 8) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
